FILE: design/assert_macros.svh
// Assertion macros used by the checker file psa_chk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge outside reset.
`define CHK_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define CHK_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/psa_pkg.sv
// ----------------------------------------------------------------------------
// psa_pkg
// Shared constants and types of the paged slot allocator.
// ----------------------------------------------------------------------------
`default_nettype none
package psa_pkg;

    localparam int FREE_DEPTH    = 256;
    localparam int MAX_NEW_PAGES = 62;
    localparam int FIFO_AW       = $clog2(FREE_DEPTH);
    localparam int FIFO_CW       = $clog2(FREE_DEPTH + 1);
    localparam int PAGE_MAX      = 4096;

    // error codes
    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_SHRINK  = 2'd1;
    localparam logic [1:0] ERR_EMPTY   = 2'd2;
    localparam logic [1:0] ERR_TOOMANY = 2'd3;

    // request types
    localparam logic REQ_PUSH  = 1'b0;
    localparam logic REQ_ALLOC = 1'b1;

    // register index of the tokens-per-page register
    localparam logic REG_PG_TOKENS = 1'b0;

    // divider status toward the sequencer
    typedef struct packed {
        logic        done;
        logic [31:0] quo;
        logic [12:0] rem;
    } psa_div_res_t;

endpackage
`default_nettype wire

FILE: design/psa_if.sv
// ----------------------------------------------------------------------------
// psa_req_if / psa_run_if
// Valid/ready channels for requests in and runs out.
// ----------------------------------------------------------------------------
`default_nettype none
interface psa_req_if;
    logic               valid;
    logic               ready;
    logic               req_type;
    logic [31:0]        free_page;
    logic [31:0]        prev_len;
    logic [31:0]        new_len;
    logic signed [40:0] last_slot;
    modport source (output valid, req_type, free_page, prev_len, new_len, last_slot,
                    input ready);
    modport sink   (input valid, req_type, free_page, prev_len, new_len, last_slot,
                    output ready);
endinterface

interface psa_run_if;
    logic        valid;
    logic        ready;
    logic [39:0] run_start;
    logic [12:0] run_len;
    logic        is_last;
    logic [1:0]  error;
    modport source (output valid, run_start, run_len, is_last, error, input ready);
    modport sink   (input valid, run_start, run_len, is_last, error, output ready);
endinterface
`default_nettype wire

FILE: design/psa_div.sv
// ----------------------------------------------------------------------------
// psa_div
// Restoring divider, 32-bit dividend by 13-bit divisor, one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module psa_div
    import psa_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [31:0]  dividend,
    input  wire logic [12:0]  divisor,
    output psa_div_res_t      res
);

    logic [31:0] dvd_reg, dvd_next;
    logic [12:0] rem_reg, rem_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        done_reg, done_next;
    logic [13:0] trial;
    logic        qbit;

    // one shift-subtract step
    always_comb
    begin
        trial     = {rem_reg, dvd_reg[31]};
        qbit      = (trial >= {1'b0, divisor});
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            dvd_next = dividend;
            rem_next = '0;
            cnt_next = 6'd32;
        end
        else if (cnt_reg != 6'd0)
        begin
            rem_next  = qbit ? 13'(trial - {1'b0, divisor}) : trial[12:0];
            dvd_next  = {dvd_reg[30:0], qbit};
            cnt_next  = cnt_reg - 6'd1;
            done_next = (cnt_reg == 6'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

    assign res.done = done_reg;
    assign res.quo  = dvd_reg;
    assign res.rem  = rem_reg;

endmodule
`default_nettype wire

FILE: design/paged_slot_allocator.sv
// ----------------------------------------------------------------------------
// paged_slot_allocator
// Free-page FIFO with a run generator for token slot allocation.
// ----------------------------------------------------------------------------
// A push request is taken and the block stays ready for the next request.
// An allocate request runs two divisions on one shared divider (previous
// and new length by page size), a check step, then a step for the run that
// fills the old partial page (also taken when that run is empty) and a FIFO
// read state and a run state per new page; the run sink can stall each run.
// Shrink and zero-extension markers come out of the marker state that
// follows acceptance; too-many-pages and empty-FIFO markers come out after
// the check. Free pages sit in a 256-entry memory with a registered read
// port. The block takes no new request until the last run of the current
// one is in the output register.
`default_nettype none
module paged_slot_allocator
    import psa_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    psa_req_if.sink          req_ch,
    psa_run_if.source        run_ch,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_DIV   = 7'b0000010,
        ST_CHECK = 7'b0000100,
        ST_FIRST = 7'b0001000,
        ST_POP   = 7'b0010000,
        ST_FULL  = 7'b0100000,
        ST_MARK  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [12:0] pg_tokens_reg;
    logic [12:0] ps_reg, ps_next;
    logic [31:0] prev_reg, prev_next, nlen_reg, nlen_next;
    logic [39:0] last1_reg, last1_next;
    logic        pass_reg, pass_next;
    logic [31:0] qp_reg, qp_next, qn_reg, qn_next;
    logic [12:0] rp_reg, rp_next, rn_reg, rn_next;
    logic [1:0]  err_reg, err_next;
    logic [12:0] num1_reg, num1_next;
    logic        flast_reg, flast_next;
    logic [5:0]  full_reg, full_next;
    logic        tail_reg, tail_next;

    logic [FIFO_AW-1:0] head_reg, head_next, tail_ptr_reg, tail_ptr_next;
    logic [FIFO_CW-1:0] count_reg, count_next;
    logic [31:0]        mem [FREE_DEPTH];
    logic [31:0]        rd_data_reg;
    logic               wr_en;

    logic        ov_reg, ov_next;
    logic [39:0] os_reg, os_next;
    logic [12:0] ol_reg, ol_next;
    logic        olast_reg, olast_next;
    logic [1:0]  oerr_reg, oerr_next;

    logic         div_start;
    logic [31:0]  div_dvd;
    psa_div_res_t div_res;

    logic        out_free, req_acc;
    logic [12:0] ps_eff;
    logic [32:0] pages_old, after, need, full_w;
    logic [31:0] diff;
    logic [12:0] room;
    logic [44:0] prod;

    // config register
    assign pready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pg_tokens_reg <= 13'd1;
        else if (psel && penable && pwrite && paddr[2] == REG_PG_TOKENS)
            pg_tokens_reg <= pwdata[12:0];
    end
    assign prdata = (paddr[2] == REG_PG_TOKENS) ? {19'd0, pg_tokens_reg} : 32'd0;

    // clamp page size to 1..4096
    always_comb
    begin
        priority if (pg_tokens_reg == 13'd0)
            ps_eff = 13'd1;
        else if (pg_tokens_reg > 13'(PAGE_MAX))
            ps_eff = 13'(PAGE_MAX);
        else
            ps_eff = pg_tokens_reg;
    end

    psa_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (ps_reg),
        .res      (div_res)
    );

    assign out_free     = !ov_reg || run_ch.ready;
    assign req_ch.ready = (state_reg == ST_IDLE);
    assign req_acc      = req_ch.valid && req_ch.ready;

    // page arithmetic for the check step
    assign pages_old = {1'b0, qp_reg} + {32'd0, (rp_reg != 13'd0)};
    assign after     = {1'b0, qn_reg} + {32'd0, (rn_reg != 13'd0)};
    assign need      = after - pages_old;
    assign full_w    = {1'b0, qn_reg} - pages_old;
    assign diff      = nlen_reg - prev_reg;
    assign room      = (rp_reg != 13'd0) ? 13'(ps_reg - rp_reg) : 13'd0;
    assign prod      = {13'd0, rd_data_reg} * {32'd0, ps_reg};

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        ps_next       = ps_reg;
        prev_next     = prev_reg;
        nlen_next     = nlen_reg;
        last1_next    = last1_reg;
        pass_next     = pass_reg;
        qp_next       = qp_reg;
        rp_next       = rp_reg;
        qn_next       = qn_reg;
        rn_next       = rn_reg;
        err_next      = err_reg;
        num1_next     = num1_reg;
        flast_next    = flast_reg;
        full_next     = full_reg;
        tail_next     = tail_reg;
        head_next     = head_reg;
        tail_ptr_next = tail_ptr_reg;
        count_next    = count_reg;
        wr_en         = 1'b0;
        div_start     = 1'b0;
        div_dvd       = prev_reg;
        ov_next       = ov_reg && !run_ch.ready;
        os_next       = os_reg;
        ol_next       = ol_reg;
        olast_next    = olast_reg;
        oerr_next     = oerr_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_acc)
                begin
                    if (req_ch.req_type == REQ_PUSH)
                    begin
                        if (count_reg < FIFO_CW'(FREE_DEPTH))
                        begin
                            wr_en         = 1'b1;
                            tail_ptr_next = (tail_ptr_reg == FIFO_AW'(FREE_DEPTH - 1)) ?
                                            '0 : tail_ptr_reg + 1'b1;
                            count_next    = count_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        ps_next    = ps_eff;
                        prev_next  = req_ch.prev_len;
                        nlen_next  = req_ch.new_len;
                        last1_next = req_ch.last_slot[39:0] + 40'd1;
                        pass_next  = 1'b0;
                        if (req_ch.new_len < req_ch.prev_len)
                        begin
                            err_next   = ERR_SHRINK;
                            state_next = ST_MARK;
                        end
                        else if (req_ch.new_len == req_ch.prev_len)
                        begin
                            err_next   = ERR_NONE;
                            state_next = ST_MARK;
                        end
                        else
                        begin
                            div_start  = 1'b1;
                            div_dvd    = req_ch.prev_len;
                            state_next = ST_DIV;
                        end
                    end
                end
            end
            ST_DIV:
            begin
                if (div_res.done)
                begin
                    if (!pass_reg)
                    begin
                        qp_next   = div_res.quo;
                        rp_next   = div_res.rem;
                        pass_next = 1'b1;
                        div_start = 1'b1;
                        div_dvd   = nlen_reg;
                    end
                    else
                    begin
                        qn_next    = div_res.quo;
                        rn_next    = div_res.rem;
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK:
            begin
                num1_next  = (diff < {19'd0, room}) ? diff[12:0] : room;
                flast_next = (diff <= {19'd0, room});
                full_next  = full_w[5:0];
                tail_next  = (rn_reg != 13'd0);
                priority if (need > 33'(MAX_NEW_PAGES))
                begin
                    err_next   = ERR_TOOMANY;
                    state_next = ST_MARK;
                end
                else if (need > {{(33-FIFO_CW){1'b0}}, count_reg})
                begin
                    err_next   = ERR_EMPTY;
                    state_next = ST_MARK;
                end
                else
                    state_next = ST_FIRST;
            end
            ST_FIRST:
            begin
                // fill the rest of the old partial page
                if (num1_reg == 13'd0)
                    state_next = ST_POP;
                else if (out_free)
                begin
                    ov_next    = 1'b1;
                    os_next    = last1_reg;
                    ol_next    = num1_reg;
                    olast_next = flast_reg;
                    oerr_next  = ERR_NONE;
                    state_next = flast_reg ? ST_IDLE : ST_POP;
                end
            end
            ST_POP:
            begin
                // FIFO head read settles here
                state_next = ST_FULL;
            end
            ST_FULL:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    os_next    = prod[39:0];
                    oerr_next  = ERR_NONE;
                    head_next  = (head_reg == FIFO_AW'(FREE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
                    count_next = count_reg - 1'b1;
                    if (full_reg != 6'd0)
                    begin
                        ol_next    = ps_reg;
                        olast_next = (full_reg == 6'd1) && !tail_reg;
                        full_next  = full_reg - 6'd1;
                        state_next = ((full_reg == 6'd1) && !tail_reg) ? ST_IDLE : ST_POP;
                    end
                    else
                    begin
                        ol_next    = rn_reg;
                        olast_next = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_MARK:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    os_next    = '0;
                    ol_next    = '0;
                    olast_next = 1'b1;
                    oerr_next  = err_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            head_reg     <= '0;
            tail_ptr_reg <= '0;
            count_reg    <= '0;
            ov_reg       <= 1'b0;
            pass_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            tail_ptr_reg <= tail_ptr_next;
            count_reg    <= count_next;
            ov_reg       <= ov_next;
            pass_reg     <= pass_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        ps_reg    <= ps_next;
        prev_reg  <= prev_next;
        nlen_reg  <= nlen_next;
        last1_reg <= last1_next;
        qp_reg    <= qp_next;
        rp_reg    <= rp_next;
        qn_reg    <= qn_next;
        rn_reg    <= rn_next;
        err_reg   <= err_next;
        num1_reg  <= num1_next;
        flast_reg <= flast_next;
        full_reg  <= full_next;
        tail_reg  <= tail_next;
        os_reg    <= os_next;
        ol_reg    <= ol_next;
        olast_reg <= olast_next;
        oerr_reg  <= oerr_next;
    end

    // free page memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[tail_ptr_reg] <= req_ch.free_page;
        rd_data_reg <= mem[head_reg];
    end

    assign run_ch.valid     = ov_reg;
    assign run_ch.run_start = os_reg;
    assign run_ch.run_len   = ol_reg;
    assign run_ch.is_last   = olast_reg;
    assign run_ch.error     = oerr_reg;

endmodule
`default_nettype wire

FILE: design/psa_chk.sv
// ----------------------------------------------------------------------------
// psa_chk
// Port-level checks of the paged slot allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module psa_chk
    import psa_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        req_ready,
    input wire logic        run_valid,
    input wire logic        run_ready,
    input wire logic [39:0] run_start,
    input wire logic [12:0] run_len,
    input wire logic        is_last,
    input wire logic [1:0]  error
);

    // stalled run holds
    `CHK_ASSERT(a_run_hold, run_valid && !run_ready |=> run_valid && $stable(run_start) && $stable(run_len) && $stable(is_last) && $stable(error), "stalled run changed")

    // error markers are empty final runs
    `CHK_ASSERT(a_err_marker, run_valid && error != ERR_NONE |-> run_len == 13'd0 && is_last && run_start == 40'd0, "bad error marker")

    // no new request while a request still has runs to come
    `CHK_ASSERT(a_busy, run_valid && !is_last |-> !req_ready, "request taken mid-sequence")

    // no run shown out of reset
    `CHK_ASSERT_ALWAYS(a_reset, !rst_n |-> !run_valid, "run valid in reset")

endmodule

bind paged_slot_allocator psa_chk u_psa_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_ready (req_ch.ready),
    .run_valid (run_ch.valid),
    .run_ready (run_ch.ready),
    .run_start (run_ch.run_start),
    .run_len   (run_ch.run_len),
    .is_last   (run_ch.is_last),
    .error     (run_ch.error)
);
`default_nettype wire

FILE: tb/sv/paged_slot_allocator_test.sv
// ----------------------------------------------------------------------------
// paged_slot_allocator_test
// Self-checking bench for the paged slot allocator. Free pages are pushed and
// requests are extended under several page sizes. A local predictor keeps
// its own free-page queue and works out every run. A checker compares each
// run leaving the block with the oldest predicted run.
// ----------------------------------------------------------------------------
`default_nettype none
module paged_slot_allocator_test;
    import psa_pkg::*;

    localparam int          HALF_PERIOD = 10;
    localparam int          SETTLE      = 150;
    localparam longint      CYCLE_LIMIT = 3000000;
    localparam logic [2:0]  ADDR_PG_TOKENS = {REG_PG_TOKENS, 2'b00};

    typedef struct {
        logic [39:0] start;
        logic [12:0] len;
        logic        last;
        logic [1:0]  err;
    } run_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    psa_req_if req_ch ();
    psa_run_if run_ch ();

    paged_slot_allocator dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req_ch  (req_ch.sink),
        .run_ch  (run_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predictor state
    logic [12:0]  pg_tokens;
    logic [31:0]  pool_q[$];
    run_t         expected_runs[$];

    int           fail_count;
    int           runs_checked;
    int           allocs_sent;
    int           pushes_sent;
    longint       cycle_count;
    bit           quiet;          // no idling on either side while set

    always #HALF_PERIOD clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic longint unsigned eff_pg_tokens();
        if (pg_tokens == 13'd0)
            return 1;
        if (pg_tokens > PAGE_MAX)
            return PAGE_MAX;
        return pg_tokens;
    endfunction

    function automatic void push_run(logic [39:0] start, logic [12:0] len,
                                     logic last, logic [1:0] err);
        run_t r;
        r.start = start;
        r.len   = len;
        r.last  = last;
        r.err   = err;
        expected_runs.push_back(r);
    endfunction

    // runs that one allocate request produces; pops predicted pages
    function automatic void predict_alloc(logic [31:0] prev_len, logic [31:0] new_len,
                                          logic signed [40:0] last_slot);
        longint unsigned ps, prv, nl, before_pg, after_pg, need, boundary;
        longint unsigned first_cnt, full_end, p, page;
        logic [40:0]     next_slot;
        ps = eff_pg_tokens();
        prv = prev_len;
        nl = new_len;
        next_slot = last_slot + 41'sd1;
        if (nl < prv)
        begin
            push_run('0, '0, 1'b1, ERR_SHRINK);
            return;
        end
        if (nl == prv)
        begin
            push_run('0, '0, 1'b1, ERR_NONE);
            return;
        end
        before_pg = (prv + ps - 1) / ps;
        after_pg = (nl + ps - 1) / ps;
        need = after_pg - before_pg;
        if (need > MAX_NEW_PAGES)
        begin
            push_run('0, '0, 1'b1, ERR_TOOMANY);
            return;
        end
        if (need > pool_q.size())
        begin
            push_run('0, '0, 1'b1, ERR_EMPTY);
            return;
        end
        boundary = before_pg * ps;
        first_cnt = ((nl < boundary) ? nl : boundary) - prv;
        // tail of the old partial page
        if (first_cnt > 0)
            push_run(next_slot[39:0], first_cnt[12:0], (prv + first_cnt == nl), ERR_NONE);
        if (prv + first_cnt == nl)
            return;
        full_end = (nl / ps) * ps;
        for (p = boundary; p < full_end; p += ps)
        begin
            page = pool_q.pop_front();
            page = page * ps;
            push_run(page[39:0], ps[12:0], (p + ps == nl), ERR_NONE);
        end
        if (full_end < nl)
        begin
            page = pool_q.pop_front();
            page = page * ps;
            p = nl - full_end;
            push_run(page[39:0], p[12:0], 1'b1, ERR_NONE);
        end
    endfunction

    function automatic int draw_gap();
        return quiet ? 0 : $urandom_range(0, 13);
    endfunction

    // send one request; valid stays high when the next one follows at once
    task automatic send_req(logic kind, logic [31:0] page, logic [31:0] prev_len,
                            logic [31:0] new_len, logic signed [40:0] last_slot);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.req_type  <= kind;
        req_ch.free_page <= page;
        req_ch.prev_len  <= prev_len;
        req_ch.new_len   <= new_len;
        req_ch.last_slot <= last_slot;
        do
            @(posedge clk);
        while (!req_ch.ready);
        if (kind == REQ_PUSH)
        begin
            pushes_sent++;
            if (pool_q.size() < FREE_DEPTH)
                pool_q.push_back(page);
        end
        else
        begin
            allocs_sent++;
            predict_alloc(prev_len, new_len, last_slot);
        end
    endtask

    task automatic push_page(logic [31:0] page);
        send_req(REQ_PUSH, page, $urandom, $urandom, 41'({$urandom, $urandom}));
    endtask

    task automatic alloc(logic [31:0] prev_len, logic [31:0] new_len,
                         logic signed [40:0] last_slot);
        send_req(REQ_ALLOC, $urandom, prev_len, new_len, last_slot);
    endtask

    // lower valid, wait for every predicted run, then let the block settle
    task automatic drain();
        req_ch.valid <= 1'b0;
        while (expected_runs.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_pg_tokens(logic [12:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_PG_TOKENS;
        pwdata  <= {19'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        pg_tokens = value;
    endtask

    // run checker
    initial
    begin
        run_t exp_run;
        run_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            int stall;
            stall = draw_gap();
            if (stall > 0)
            begin
                run_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            run_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!run_ch.valid);
            if (expected_runs.size() == 0)
            begin
                $error("run with nothing expected: start %h len %0d",
                       run_ch.run_start, run_ch.run_len);
                fail_count++;
            end
            else
            begin
                exp_run = expected_runs.pop_front();
                runs_checked++;
                if (run_ch.run_start !== exp_run.start)
                begin
                    $error("run_start expected %h got %h", exp_run.start, run_ch.run_start);
                    fail_count++;
                end
                if (run_ch.run_len !== exp_run.len)
                begin
                    $error("run_len expected %0d got %0d", exp_run.len, run_ch.run_len);
                    fail_count++;
                end
                if (run_ch.is_last !== exp_run.last)
                begin
                    $error("is_last expected %b got %b", exp_run.last, run_ch.is_last);
                    fail_count++;
                end
                if (run_ch.error !== exp_run.err)
                begin
                    $error("error expected %0d got %0d", exp_run.err, run_ch.error);
                    fail_count++;
                end
            end
        end
    end

    // small page: partial first page, full pages, tail, empty and shrink markers
    task automatic test_basic_runs();
        write_pg_tokens(13'd4);
        push_page(32'h0000_0000);
        push_page(32'hFFFF_FFFF);
        push_page(32'h0000_0005);
        push_page(32'h8000_0001);
        alloc(32'd0, 32'd1, -41'sd1);
        alloc(32'd1, 32'd10, 41'sd0);
        alloc(32'd10, 32'd12, 41'h0FF_FFFF_FFFF);
        alloc(32'd0, 32'd8, -41'sd1);
        alloc(32'd12, 32'd12, 41'sd7);
        alloc(32'd12, 32'd11, 41'sd7);
        alloc(32'hFFFF_FFFF, 32'hFFFF_FFFF, -41'sd2);
        alloc(32'hFFFF_FFFF, 32'h0000_0000, 41'h100_0000_0000);
        drain();
    endtask

    // largest page: 62 pages, one too many, then clamped page sizes
    task automatic test_page_limits();
        write_pg_tokens(13'd4096);
        alloc(32'd0, 32'd4096 * 63, -41'sd1);
        alloc(32'd100, 32'd4096 * 62, 41'sd99);
        alloc(32'd0, 32'd1, -41'sd1);
        push_page(32'hFFFF_FFFF);
        alloc(32'd0, 32'd4096, 41'sd0);
        drain();
        write_pg_tokens(13'd8191);
        push_page(32'h0000_0003);
        alloc(32'd4095, 32'd4097, 41'sd4094);
        drain();
        write_pg_tokens(13'd0);
        push_page(32'h0000_0009);
        alloc(32'd0, 32'd1, -41'sd1);
        alloc(32'd0, 32'd63, -41'sd1);
        drain();
    endtask

    // fill to capacity; the push past the last free entry is dropped
    task automatic test_full_queue();
        int i;
        write_pg_tokens(13'd1);
        for (i = 0; i < FREE_DEPTH; i++)
            push_page($urandom);
        drain();
    endtask

    // random mix of pushes, well-formed extensions and broken requests
    task automatic test_random_traffic(int count);
        longint unsigned ps, prv, nl;
        int i, kind;
        ps = eff_pg_tokens();
        for (i = 0; i < count; i++)
        begin
            if ((i % 40) == 0)
                quiet = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) < 4 || pool_q.size() < 4)
                push_page($urandom);
            else
            begin
                kind = $urandom_range(0, 19);
                if ($urandom_range(0, 2) == 0)
                    prv = $urandom_range(0, 32'hFFFF_FFFF - 32'd300000);
                else
                    prv = $urandom_range(0, ps * 8);
                case (kind)
                    0: nl = $urandom_range(0, 32'hFFFF_FFFF);
                    1: nl = prv;
                    2: nl = prv + ps * $urandom_range(63, 70);
                    default: nl = prv + $urandom_range(1, ps * $urandom_range(1, 7));
                endcase
                if (nl > 64'hFFFF_FFFF)
                    nl = 64'hFFFF_FFFF;
                alloc(prv[31:0], nl[31:0], 41'({$urandom_range(0, 511), $urandom}));
            end
        end
        quiet = 1'b0;
        drain();
    endtask

    initial
    begin
        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        req_ch.valid <= 1'b0;
        req_ch.req_type <= REQ_PUSH;
        req_ch.free_page <= '0;
        req_ch.prev_len <= '0;
        req_ch.new_len <= '0;
        req_ch.last_slot <= '0;
        pg_tokens = 13'd1;
        fail_count = 0;
        runs_checked = 0;
        allocs_sent = 0;
        pushes_sent = 0;
        cycle_count = 0;
        quiet = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_runs();
        test_full_queue();
        test_page_limits();
        write_pg_tokens(13'd3);
        test_random_traffic(6);
        write_pg_tokens(13'd1);
        test_random_traffic(4);
        write_pg_tokens(13'($urandom_range(2, 64)));
        test_random_traffic(6);

        $display("covered %0d pushes and %0d allocate requests over several page sizes",
                 pushes_sent, allocs_sent);
        $display("%0d runs checked, %0d mismatches", runs_checked, fail_count);
        if (fail_count == 0 && expected_runs.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
`default_nettype wire
